/* sv/ssvf_pkg.sv */
// ssvf_pkg: shared widths, reset values, codes and types for the stereo
// state-variable filter. No dependencies; used by every other file.
`default_nettype none

package ssvf_pkg;

  // sample and state widths
  localparam int SAMPLE_BITS    = 24;
  localparam int STATE_W        = 32;
  localparam int COEF_W         = 15;
  localparam int COEF_FRAC_BITS = 14;
  localparam int MODE_W         = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COEF_W;

  // register reset values
  localparam logic [COEF_W-1:0] FREQ_RESET = COEF_W'(2333);
  localparam logic [COEF_W-1:0] DAMP_RESET = COEF_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ = 2'd0,
    CFG_DAMP = 2'd1,
    CFG_MODE = 2'd2
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOW   = 2'd0,
    MODE_BAND  = 2'd1,
    MODE_NOTCH = 2'd2,
    MODE_HIGH  = 2'd3
  } filter_mode_e;

  // payload of one transfer on each channel
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;    // capture input samples
    logic mul_en;     // load the product register
    logic coef_damp;  // multiplier coefficient: damping instead of frequency
    logic op_high;    // multiplier operand: high instead of band
    logic upd_low;    // low integrator update
    logic upd_high;   // high-pass value update
    logic upd_band;   // band integrator update
    logic load_out;   // load the output register
  } cmd_t;

endpackage

`default_nettype wire

/* sv/stereo_state_variable_filter.sv */
// stereo_state_variable_filter: top level, controller plus datapath.
// Depends on ssvf_pkg, ssvf_ctrl and ssvf_datapath.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_data_i  (left_in, right_in)
//   out      output     out_valid_o / out_ready_i out_data_o (left_out, right_out)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// An item goes from its transfer in through the states LOW, HIGH, MFH, BAND and
// OUT to the result register, and the block is ready again on the next cycle:
// the three products per channel go one after another through one multiplier
// per lane, each followed by its saturating add, then the output select.
// Items are taken one at a time; a new item is taken once the previous result
// has been loaded into the output register, which may still be waiting.
// A stalled output holds the block in its final step until the register frees.
// Reset clears the integrators and sets the coefficients to their defaults.
`default_nettype none

module stereo_state_variable_filter #(
  parameter int CoefFracBits = ssvf_pkg::COEF_FRAC_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_ready_o,
  input  wire ssvf_pkg::in_item_t               in_data_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      ssvf_pkg::out_item_t              out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ssvf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ssvf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  ssvf_pkg::cmd_t cmd;

  // sequencer
  ssvf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // arithmetic and configuration
  ssvf_datapath #(
    .CoefFracBits(CoefFracBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* sv/ssvf_lane.sv */
// ssvf_lane: one channel of the filter datapath - integrators, shared
// multiplier, saturating adders and output select. Depends on ssvf_pkg.
`default_nettype none

module ssvf_lane #(
  parameter int CoefFracBits = ssvf_pkg::COEF_FRAC_BITS
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire ssvf_pkg::cmd_t                           cmd_i,
  input  wire logic signed [ssvf_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  wire logic        [ssvf_pkg::COEF_W-1:0]       freq_i,
  input  wire logic        [ssvf_pkg::COEF_W-1:0]       damp_i,
  input  wire logic        [ssvf_pkg::MODE_W-1:0]       mode_i,
  output      logic signed [ssvf_pkg::SAMPLE_BITS-1:0]  y_o
);

  localparam int StW   = ssvf_pkg::STATE_W;
  localparam int SmpW  = ssvf_pkg::SAMPLE_BITS;
  localparam int ProdW = ssvf_pkg::COEF_W + 1 + StW;
  localparam int ShW   = ProdW - CoefFracBits;
  localparam int AccW  = ShW + 2;

  localparam logic signed [AccW-1:0] AccHi =
    {{(AccW-StW+1){1'b0}}, {(StW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccLo =
    {{(AccW-StW+1){1'b1}}, {(StW-1){1'b0}}};
  localparam logic signed [StW:0] OutHi =
    {{(StW-SmpW+2){1'b0}}, {(SmpW-1){1'b1}}};
  localparam logic signed [StW:0] OutLo =
    {{(StW-SmpW+2){1'b1}}, {(SmpW-1){1'b0}}};

  // clip a wide sum to the state range
  function automatic logic signed [StW-1:0] sat_state(input logic signed [AccW-1:0] v);
    logic signed [StW-1:0] r;
    if (v > AccHi) r = AccHi[StW-1:0];
    else if (v < AccLo) r = AccLo[StW-1:0];
    else r = v[StW-1:0];
    return r;
  endfunction

  // clip a selected value to the sample range
  function automatic logic signed [SmpW-1:0] sat_out(input logic signed [StW:0] v);
    logic signed [SmpW-1:0] r;
    if (v > OutHi) r = OutHi[SmpW-1:0];
    else if (v < OutLo) r = OutLo[SmpW-1:0];
    else r = v[SmpW-1:0];
    return r;
  endfunction

  logic signed [StW-1:0]   low_q, low_d;
  logic signed [StW-1:0]   band_q, band_d;
  logic signed [StW-1:0]   high_q;
  logic signed [SmpW-1:0]  in_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [SmpW-1:0]  y_q, y_d;

  logic signed [ssvf_pkg::COEF_W:0] coef_op;
  logic signed [StW-1:0]            mul_op;
  logic signed [ShW-1:0]            prod_sh;
  logic signed [AccW-1:0]           low_sum, high_sum, band_sum;
  logic signed [StW:0]              notch, y_wide;

  // shared multiplier, coefficient zero-extended to signed
  assign coef_op = $signed({1'b0, (cmd_i.coef_damp ? damp_i : freq_i)});
  assign mul_op  = cmd_i.op_high ? high_q : band_q;
  assign prod_d  = coef_op * mul_op;

  // scaled product, floor rounding by dropping fraction bits
  assign prod_sh = $signed(prod_q[ProdW-1:CoefFracBits]);

  // integrator and high-pass sums
  assign low_sum  = AccW'(low_q) + AccW'(prod_sh);
  assign high_sum = AccW'(in_q) - AccW'(low_q) - AccW'(prod_sh);
  assign band_sum = AccW'(band_q) + AccW'(prod_sh);

  assign low_d  = cmd_i.upd_low  ? sat_state(low_sum)  : low_q;
  assign band_d = cmd_i.upd_band ? sat_state(band_sum) : band_q;

  // output select
  assign notch = (StW+1)'(high_q) + (StW+1)'(low_q);

  always_comb begin
    unique case (ssvf_pkg::filter_mode_e'(mode_i))
      ssvf_pkg::MODE_LOW:   y_wide = (StW+1)'(low_q);
      ssvf_pkg::MODE_BAND:  y_wide = (StW+1)'(band_q);
      ssvf_pkg::MODE_NOTCH: y_wide = notch;
      ssvf_pkg::MODE_HIGH:  y_wide = (StW+1)'(high_q);
      default:              y_wide = (StW+1)'(low_q);
    endcase
  end

  assign y_d = cmd_i.load_out ? sat_out(y_wide) : y_q;

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      band_q <= '0;
    end else begin
      low_q  <= low_d;
      band_q <= band_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= sample_i;
    if (cmd_i.mul_en) prod_q <= prod_d;
    if (cmd_i.upd_high) high_q <= sat_state(high_sum);
    y_q <= y_d;
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

/* sv/ssvf_datapath.sv */
// ssvf_datapath: configuration registers and the two channel lanes.
// Depends on ssvf_pkg and ssvf_lane.
`default_nettype none

module ssvf_datapath #(
  parameter int CoefFracBits = ssvf_pkg::COEF_FRAC_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ssvf_pkg::cmd_t                      cmd_i,
  input  wire ssvf_pkg::in_item_t                  in_data_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [ssvf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ssvf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output      ssvf_pkg::out_item_t                 out_data_o
);

  logic [ssvf_pkg::COEF_W-1:0] freq_q, freq_d;
  logic [ssvf_pkg::COEF_W-1:0] damp_q, damp_d;
  logic [ssvf_pkg::MODE_W-1:0] mode_q, mode_d;

  // register writes, unknown index ignored
  always_comb begin
    freq_d = freq_q;
    damp_d = damp_q;
    mode_d = mode_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssvf_pkg::CFG_FREQ: freq_d = cfg_wdata_i[ssvf_pkg::COEF_W-1:0];
        ssvf_pkg::CFG_DAMP: damp_d = cfg_wdata_i[ssvf_pkg::COEF_W-1:0];
        ssvf_pkg::CFG_MODE: mode_d = cfg_wdata_i[ssvf_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= ssvf_pkg::FREQ_RESET;
      damp_q <= ssvf_pkg::DAMP_RESET;
      mode_q <= ssvf_pkg::MODE_LOW;
    end else begin
      freq_q <= freq_d;
      damp_q <= damp_d;
      mode_q <= mode_d;
    end
  end

  // left lane
  ssvf_lane #(
    .CoefFracBits(CoefFracBits)
  ) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .sample_i (in_data_i.left_in),
    .freq_i   (freq_q),
    .damp_i   (damp_q),
    .mode_i   (mode_q),
    .y_o      (out_data_o.left_out)
  );

  // right lane
  ssvf_lane #(
    .CoefFracBits(CoefFracBits)
  ) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .sample_i (in_data_i.right_in),
    .freq_i   (freq_q),
    .damp_i   (damp_q),
    .mode_i   (mode_q),
    .y_o      (out_data_o.right_out)
  );

endmodule

`default_nettype wire

/* sv/ssvf_ctrl.sv */
// ssvf_ctrl: sequencer for the filter steps and the handshakes of both
// channels. Depends on ssvf_pkg.
`default_nettype none

module ssvf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  output      logic            out_valid_o,
  input  wire logic            out_ready_i,
  output      ssvf_pkg::cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOW  = 6'b000010,
    S_HIGH = 6'b000100,
    S_MFH  = 6'b001000,
    S_BAND = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer, out_free;

  assign in_xfer  = (state_q == S_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_LOW;
      S_LOW:  state_d = S_HIGH;
      S_HIGH: state_d = S_MFH;
      S_MFH:  state_d = S_BAND;
      S_BAND: state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.load_in   = in_xfer;
    cmd_o.mul_en    = in_xfer || (state_q == S_LOW) || (state_q == S_MFH);
    cmd_o.coef_damp = (state_q == S_LOW);
    cmd_o.op_high   = (state_q == S_MFH);
    cmd_o.upd_low   = (state_q == S_LOW);
    cmd_o.upd_high  = (state_q == S_HIGH);
    cmd_o.upd_band  = (state_q == S_BAND);
    cmd_o.load_out  = (state_q == S_OUT) && out_free;
  end

  // output valid flag
  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* sv/ssvf_checker.sv */
// ssvf_checker: port-level checks on the filter top level, attached by bind.
// Depends on ssvf_pkg.
`default_nettype none

module ssvf_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire ssvf_pkg::out_item_t  out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // busy straight after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // no result the cycle after a transfer into an empty output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  // a fresh result leaves the block ready for the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("not ready after loading a result");

endmodule

bind stereo_state_variable_filter ssvf_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
